// ===== rtl/core/top_k_score_keeper_assert.svh =====
`ifndef TOP_K_SCORE_KEEPER_ASSERT_SVH
`define TOP_K_SCORE_KEEPER_ASSERT_SVH

// Checks that are meaningful only once reset has been released.
`define TKS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that must also hold while reset is asserted.
`define TKS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tks_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int SCORE_BITS  = 32;
  localparam int TAG_BITS    = 32;
  localparam int CAP_W       = 5;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int DATA_BITS   = SCORE_BITS + TAG_BITS;
  localparam int TDATA_W     = ((DATA_BITS + 7) / 8) * 8;
  localparam int CAP_RESET   = 16;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_REPLACED = 3'd1,
    ST_REJECTED = 3'd2,
    ST_DUMP     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     wrap;
    logic     occupied;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/tks_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tks_cell (
  input  wire                                clk,
  input  wire tks_pkg::cell_ctrl_t           ctrl,
  input  wire logic signed [tks_pkg::SCORE_BITS-1:0] new_score,
  input  wire logic        [tks_pkg::TAG_BITS-1:0]   new_tag,
  input  wire logic                          left_cmp,
  input  wire logic signed [tks_pkg::SCORE_BITS-1:0] left_score,
  input  wire logic        [tks_pkg::TAG_BITS-1:0]   left_tag,
  input  wire logic signed [tks_pkg::SCORE_BITS-1:0] right_score,
  input  wire logic        [tks_pkg::TAG_BITS-1:0]   right_tag,
  input  wire logic signed [tks_pkg::SCORE_BITS-1:0] head_score,
  input  wire logic        [tks_pkg::TAG_BITS-1:0]   head_tag,
  output logic signed      [tks_pkg::SCORE_BITS-1:0] score,
  output logic             [tks_pkg::TAG_BITS-1:0]   tag,
  output logic                               cmp
);
  import tks_pkg::*;

  // The new item goes ahead of this entry only on a strictly greater score.
  assign cmp = !ctrl.occupied || (new_score > score);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (left_cmp) begin
          score <= left_score;
          tag   <= left_tag;
        end else if (cmp) begin
          score <= new_score;
          tag   <= new_tag;
        end
      end
      CELL_ROTATE: begin
        if (ctrl.wrap) begin
          score <= head_score;
          tag   <= head_tag;
        end else begin
          score <= right_score;
          tag   <= right_tag;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/top_k_score_keeper.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "top_k_score_keeper_assert.svh"
// Keeps the highest-scoring entries seen so far in a sorted row of cells, best
// first, up to the capacity register (0 acts as 1, values above the built depth
// act as the depth). An insert word is decided and written into the row in the
// cycle it is accepted, so inserts go at one per cycle whenever no dump is
// running and the result register is free; its single result word reports
// stored, replaced or rejected. A dump word first enters the dump state and
// then streams the kept entries, best first, one per cycle while the receiver
// takes them, by rotating the row through its head cell; an empty store
// returns a single empty word. Equal scores are listed oldest first and never
// replace. Writing the capacity never drops entries.
module top_k_score_keeper (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [tks_pkg::TDATA_W-1:0]       s_tdata,  // score, tag
  input  wire  [0:0]                        s_tuser,  // op
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [tks_pkg::TDATA_W-1:0]       m_tdata,  // out_score, out_tag
  output logic [2:0]                        m_tuser,  // status
  output logic                              m_tlast,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [tks_pkg::CAP_W-1:0]         cfg_data
);
  import tks_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t                  state;
  logic [CAP_W-1:0]        capacity;
  logic [CNT_W-1:0]        count;
  logic [IDX_W-1:0]        idx;
  status_t                 out_status;
  logic signed [SCORE_BITS-1:0] out_score;
  logic [TAG_BITS-1:0]     out_tag;
  logic                    out_last;

  logic signed [SCORE_BITS-1:0] cell_score [MAX_ENTRIES];
  logic [TAG_BITS-1:0]     cell_tag [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  cell_cmp;
  cell_ctrl_t              cell_ctrl [MAX_ENTRIES];

  logic                    in_acc;
  logic                    out_free;
  logic                    out_load;
  logic                    is_dump;
  logic signed [SCORE_BITS-1:0] ins_score;
  logic [TAG_BITS-1:0]     ins_tag;
  logic [CNT_W-1:0]        eff_cap;
  logic [IDX_W-1:0]        last_idx;
  logic                    has_room;
  logic                    beats_min;
  logic                    do_insert;
  logic                    dump_step;
  logic                    dump_last;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign in_acc    = s_tvalid && s_tready;
  assign is_dump   = s_tuser[0];
  assign ins_score = s_tdata[SCORE_BITS-1:0];
  assign ins_tag   = s_tdata[SCORE_BITS +: TAG_BITS];

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(capacity) > MAX_ENTRIES) begin
      eff_cap = CNT_W'(MAX_ENTRIES);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
  end

  assign last_idx  = IDX_W'(count - CNT_W'(1));
  assign has_room  = count < eff_cap;
  assign beats_min = cell_cmp[last_idx];
  assign do_insert = in_acc && !is_dump && (has_room || beats_min);
  assign dump_step = (state == S_DUMP) && out_free;
  assign dump_last = (CNT_W'(idx) == count - CNT_W'(1));
  assign out_load  = (in_acc && !(is_dump && (count != '0))) || dump_step;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic signed [SCORE_BITS-1:0] l_score;
    logic [TAG_BITS-1:0]          l_tag;
    logic signed [SCORE_BITS-1:0] r_score;
    logic [TAG_BITS-1:0]          r_tag;
    logic                         l_cmp;

    always_comb begin
      cell_ctrl[g].occupied = count > CNT_W'(g);
      cell_ctrl[g].wrap     = (last_idx == IDX_W'(g));
      if (do_insert) begin
        cell_ctrl[g].op = CELL_INSERT;
      end else if (dump_step) begin
        cell_ctrl[g].op = CELL_ROTATE;
      end else begin
        cell_ctrl[g].op = CELL_HOLD;
      end
    end

    if (g == 0) begin : g_head
      assign l_cmp   = 1'b0;
      assign l_score = cell_score[0];
      assign l_tag   = cell_tag[0];
    end else begin : g_body
      assign l_cmp   = cell_cmp[g-1];
      assign l_score = cell_score[g-1];
      assign l_tag   = cell_tag[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_tail
      assign r_score = cell_score[0];
      assign r_tag   = cell_tag[0];
    end else begin : g_inner
      assign r_score = cell_score[g+1];
      assign r_tag   = cell_tag[g+1];
    end

    tks_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl[g]),
      .new_score   (ins_score),
      .new_tag     (ins_tag),
      .left_cmp    (l_cmp),
      .left_score  (l_score),
      .left_tag    (l_tag),
      .right_score (r_score),
      .right_tag   (r_tag),
      .head_score  (cell_score[0]),
      .head_tag    (cell_tag[0]),
      .score       (cell_score[g]),
      .tag         (cell_tag[g]),
      .cmp         (cell_cmp[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
      idx      <= '0;
      capacity <= CAP_W'(CAP_RESET);
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (do_insert && has_room) begin
        count <= count + CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            out_score <= '0;
            out_tag   <= '0;
            out_last  <= 1'b1;
            if (is_dump) begin
              if (count == '0) begin
                out_status <= ST_EMPTY;
              end else begin
                state <= S_DUMP;
                idx   <= '0;
              end
            end else begin
              if (has_room) begin
                out_status <= ST_STORED;
              end else if (beats_min) begin
                out_status <= ST_REPLACED;
              end else begin
                out_status <= ST_REJECTED;
              end
            end
          end
        end
        S_DUMP: begin
          if (dump_step) begin
            out_status <= ST_DUMP;
            out_score  <= cell_score[0];
            out_tag    <= cell_tag[0];
            out_last   <= dump_last;
            idx        <= idx + IDX_W'(1);
            if (dump_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[SCORE_BITS-1:0]        = out_score;
    m_tdata[SCORE_BITS +: TAG_BITS] = out_tag;
  end
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  `TKS_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "word valid after reset")
  `TKS_ASSERT(a_count_bound, count <= CNT_W'(MAX_ENTRIES), "kept count above depth")
  `TKS_ASSERT(a_dump_idx, (state == S_DUMP) |-> (CNT_W'(idx) < count),
              "dump index past count")
  `TKS_ASSERT(a_store_grows,
              (do_insert && has_room) |=> (count == CNT_W'($past(count) + CNT_W'(1))),
              "store did not grow")
  `TKS_ASSERT(a_empty_last,
              (m_tvalid && (m_tuser == ST_EMPTY)) |-> (m_tlast && (count == '0)),
              "bad empty word")

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import tks_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = MAX_ENTRIES + 8;

  typedef struct {
    status_t               status;
    logic [SCORE_BITS-1:0] score;
    logic [TAG_BITS-1:0]   tag;
    logic                  last;
  } keeper_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [TDATA_W-1:0]   s_tdata = '0;
  logic [0:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;
  logic [2:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CAP_W-1:0]     cfg_data = '0;

  logic signed [SCORE_BITS-1:0] board_score [MAX_ENTRIES];
  logic [TAG_BITS-1:0]          board_tag [MAX_ENTRIES];
  int                           board_count = 0;
  int                           capacity_reg = CAP_RESET;
  keeper_word_t                 expected_words [$];

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  top_k_score_keeper i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[top_k_score_keeper] ERROR");
      $finish;
    end
  end

  // The receiver holds off for whole stretches when asked, otherwise stalls at random.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    keeper_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, status", 32'(m_tuser), 32'(0));
      end else begin
        w = expected_words.pop_front();
        if (m_tuser !== w.status) report_mismatch("status", 32'(m_tuser), 32'(w.status));
        if (m_tdata[SCORE_BITS-1:0] !== w.score)
          report_mismatch("score", m_tdata[SCORE_BITS-1:0], w.score);
        if (m_tdata[SCORE_BITS +: TAG_BITS] !== w.tag)
          report_mismatch("tag", m_tdata[SCORE_BITS +: TAG_BITS], w.tag);
        if (m_tlast !== w.last) report_mismatch("last", 32'(m_tlast), 32'(w.last));
      end
    end
  end

  task automatic predict_outcome(input logic op, input logic signed [SCORE_BITS-1:0] sc,
                                 input logic [TAG_BITS-1:0] tg);
    keeper_word_t w;
    int limit;
    int pos;
    w.score = '0;
    w.tag = '0;
    w.last = 1'b1;
    if (op == OP_DUMP) begin
      if (board_count == 0) begin
        w.status = ST_EMPTY;
        expected_words.push_back(w);
      end else begin
        for (int i = 0; i < board_count; i++) begin
          w.status = ST_DUMP;
          w.score = board_score[i];
          w.tag = board_tag[i];
          w.last = (i == board_count - 1);
          expected_words.push_back(w);
        end
      end
      return;
    end
    limit = (capacity_reg == 0) ? 1 : (capacity_reg > MAX_ENTRIES) ? MAX_ENTRIES : capacity_reg;
    pos = -1;
    if (board_count < limit) begin
      pos = board_count;
      board_count++;
      w.status = ST_STORED;
    end else if (sc > board_score[board_count-1]) begin
      pos = board_count - 1;
      w.status = ST_REPLACED;
    end else begin
      w.status = ST_REJECTED;
    end
    if (pos >= 0) begin
      // A new entry goes behind any kept entry of equal score.
      while (pos > 0 && board_score[pos-1] < sc) begin
        board_score[pos] = board_score[pos-1];
        board_tag[pos] = board_tag[pos-1];
        pos--;
      end
      board_score[pos] = sc;
      board_tag[pos] = tg;
    end
    expected_words.push_back(w);
  endtask

  task automatic send_word(input logic op, input logic [SCORE_BITS-1:0] sc,
                           input logic [TAG_BITS-1:0] tg);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {tg, sc};
    do @(posedge clk); while (!s_tready);
    predict_outcome(op, sc, tg);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input int value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data <= value[CAP_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_reg = value;
    @(posedge clk);
  endtask

  task automatic send_random_word();
    logic op;
    logic [SCORE_BITS-1:0] sc;
    int pick;
    op = ($urandom_range(99) < 10) ? OP_DUMP : OP_INSERT;
    pick = $urandom_range(3);
    case (pick)
      0, 1: sc = SCORE_BITS'($signed($urandom_range(16)) - 8);
      2: sc = $urandom;
      default: sc = $urandom_range(1) ? {1'b0, {(SCORE_BITS-1){1'b1}}} - $urandom_range(3)
                                      : {1'b1, {(SCORE_BITS-1){1'b0}}} + $urandom_range(3);
    endcase
    send_word(op, sc, $urandom);
  endtask

  task automatic test_empty_dump();
    send_word(OP_DUMP, '0, '0);
  endtask

  task automatic test_small_capacity();
    write_capacity(0);
    send_word(OP_INSERT, 32'sd5, 32'h0000_0010);
    send_word(OP_INSERT, 32'sd5, 32'h0000_0011);
    send_word(OP_INSERT, 32'sd6, 32'h0000_0012);
    send_word(OP_INSERT, 32'h8000_0000, 32'h0000_0013);
    send_word(OP_DUMP, '0, '0);
    write_capacity(1);
    send_word(OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
    send_word(OP_DUMP, '0, '0);
  endtask

  task automatic test_tie_order();
    write_capacity(4);
    send_word(OP_INSERT, 32'sd0, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'sd0, 32'h0000_0001);
    send_word(OP_INSERT, 32'h8000_0000, 32'h0000_0002);
    send_word(OP_INSERT, 32'h8000_0000, 32'h0000_0005);
    send_word(OP_INSERT, 32'sd0, 32'h0000_0003);
    send_word(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0006);
    send_word(OP_INSERT, 32'sd0, 32'h0000_0007);
    send_word(OP_INSERT, 32'sd1, 32'h0000_0004);
    send_word(OP_DUMP, '0, '0);
    write_capacity(2);
    send_word(OP_INSERT, 32'sd1, 32'h0000_0008);
    send_word(OP_DUMP, '0, '0);
  endtask

  task automatic run_random_phase(input int cap, input int sidle, input int ridle,
                                  input int count);
    write_capacity(cap);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    repeat (count) send_random_word();
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left = 150;
    repeat (20) send_random_word();
    send_word(OP_DUMP, '0, '0);
    wait_for_results();
    repeat (10) send_random_word();
    send_word(OP_DUMP, '0, '0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_dump();
    test_small_capacity();
    test_tie_order();
    run_random_phase(9, 29, 55, 70);
    run_random_phase(31, 55, 29, 70);
    run_random_phase(16, 0, 0, 40);
    test_output_stall();
    run_random_phase(3, 29, 55, 20);
    wait_for_results();
    if (error_count == 0) begin
      $display("[top_k_score_keeper] OK");
    end else begin
      $display("[top_k_score_keeper] ERROR");
    end
    $finish;
  end

endmodule
